// ===== rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Signal message deframer package
// Shared widths, message kinds, register indexes and header constants.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned CFG_IDX_W = 8;

  // Header lengths: code plus one 16-bit field, or code plus two fields.
  localparam logic [POS_W:0] HDR_SHORT   = (POS_W+1)'(3);
  localparam logic [POS_W:0] HDR_SHARING = (POS_W+1)'(5);

  // The position count holds at its largest value.
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [2:0] {
    KIND_RSSI      = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_SHARING   = 3'd2,
    KIND_IMMEDIATE = 3'd3,
    KIND_UNKNOWN   = 3'd4
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_RSSI      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_PAYLOAD   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SHARING   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_IMMEDIATE = 8'd3;

  localparam logic [BYTE_W-1:0] RST_CODE_RSSI      = 8'd1;
  localparam logic [BYTE_W-1:0] RST_CODE_PAYLOAD   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_CODE_SHARING   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_CODE_IMMEDIATE = 8'd4;

  // Matches the action code in priority order; the first match wins.
  function automatic kind_t classify(input logic [BYTE_W-1:0] b,
                                     input logic [BYTE_W-1:0] c_rssi,
                                     input logic [BYTE_W-1:0] c_payload,
                                     input logic [BYTE_W-1:0] c_sharing,
                                     input logic [BYTE_W-1:0] c_immediate);
    kind_t k;
    if (b == c_rssi) k = KIND_RSSI;
    else if (b == c_payload) k = KIND_PAYLOAD;
    else if (b == c_sharing) k = KIND_SHARING;
    else if (b == c_immediate) k = KIND_IMMEDIATE;
    else k = KIND_UNKNOWN;
    return k;
  endfunction

endpackage

// ===== rtl/signal_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Signal message deframer
// Splits a byte stream of messages into kind, header fields and payload.
// ----------------------------------------------------------------------------
// The block takes one message byte per input word and gives exactly one result
// word for each, in the cycle after acceptance, and it accepts a new byte in every
// cycle while the result register is empty or being drained: the rate is one
// word per clock, set by the single result register behind a combinational decode
// of the byte position. The first byte of a message is matched against four
// configurable action codes (rssi, payload, sharing, immediate, checked in
// that order); anything else is an unknown message. The 16-bit header fields
// that follow are little-endian: rssi for an rssi message, a length for
// payload and immediate messages, and rssi then length for a sharing message.
// Bytes after the header are passed on as payload with the payload flag set.
// On the last byte of a message (tlast) the result carries the decoded rssi and
// length and a flag saying whether the message length matches its kind and
// declared length. Action codes may be rewritten through the configuration
// port only while no message bytes are in flight; writes to indexes beyond the
// four code registers are ignored.
// ----------------------------------------------------------------------------
module signal_message_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic        s_axis_tlast,   // last_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [8] message_ok,
                                      // [24:9] rssi_value, [40:25] declared_length,
                                      // [47:41] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] msg_kind, [3] is_payload
  output logic        m_axis_tlast    // end_of_message
);

  // Action code registers.
  logic [sdf_pkg::BYTE_W-1:0] code_rssi;
  logic [sdf_pkg::BYTE_W-1:0] code_payload;
  logic [sdf_pkg::BYTE_W-1:0] code_sharing;
  logic [sdf_pkg::BYTE_W-1:0] code_immediate;

  // Message state.
  logic [sdf_pkg::POS_W-1:0]   byte_position;
  sdf_pkg::kind_t              kind_reg;
  logic [sdf_pkg::FIELD_W-1:0] rssi_reg;
  logic [sdf_pkg::FIELD_W-1:0] length_reg;

  // Result register.
  sdf_pkg::kind_t              res_kind;
  logic                        res_is_payload;
  logic [sdf_pkg::BYTE_W-1:0]  res_payload;
  logic                        res_last;
  logic                        res_ok;
  logic [sdf_pkg::FIELD_W-1:0] res_rssi;
  logic [sdf_pkg::FIELD_W-1:0] res_length;

  // Decode of the current byte.
  logic                        in_accept;
  logic                        first_byte;
  sdf_pkg::kind_t              kind_cur;
  logic [sdf_pkg::FIELD_W-1:0] rssi_next;
  logic [sdf_pkg::FIELD_W-1:0] length_next;
  logic [sdf_pkg::POS_W-1:0]   byte_position_next;
  logic [sdf_pkg::POS_W:0]     total;
  logic                        pay_flag;
  logic                        ok_flag;
  logic [sdf_pkg::FIELD_W-1:0] rssi_out;
  logic [sdf_pkg::FIELD_W-1:0] length_out;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  // The result register is refilled as it drains, so a word can enter every
  // cycle while the downstream side keeps up.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign first_byte = (byte_position == '0);
  assign total      = {1'b0, byte_position} + (sdf_pkg::POS_W+1)'(1);

  always_comb begin
    if (first_byte) begin
      kind_cur = sdf_pkg::classify(s_axis_tdata, code_rssi, code_payload,
                                   code_sharing, code_immediate);
    end else begin
      kind_cur = kind_reg;
    end

    // A new message starts from cleared header fields.
    rssi_next   = first_byte ? '0 : rssi_reg;
    length_next = first_byte ? '0 : length_reg;
    pay_flag    = 1'b0;

    case (kind_cur)
      sdf_pkg::KIND_RSSI: begin
        if (byte_position == 17'd1) rssi_next[7:0]  = s_axis_tdata;
        if (byte_position == 17'd2) rssi_next[15:8] = s_axis_tdata;
      end
      sdf_pkg::KIND_PAYLOAD, sdf_pkg::KIND_IMMEDIATE: begin
        if (byte_position == 17'd1) length_next[7:0]  = s_axis_tdata;
        if (byte_position == 17'd2) length_next[15:8] = s_axis_tdata;
        pay_flag = ({1'b0, byte_position} >= sdf_pkg::HDR_SHORT);
      end
      sdf_pkg::KIND_SHARING: begin
        if (byte_position == 17'd1) rssi_next[7:0]    = s_axis_tdata;
        if (byte_position == 17'd2) rssi_next[15:8]   = s_axis_tdata;
        if (byte_position == 17'd3) length_next[7:0]  = s_axis_tdata;
        if (byte_position == 17'd4) length_next[15:8] = s_axis_tdata;
        pay_flag = ({1'b0, byte_position} >= sdf_pkg::HDR_SHARING);
      end
      default: begin
      end
    endcase

    // End-of-message report.
    ok_flag    = 1'b0;
    rssi_out   = '0;
    length_out = '0;
    if (s_axis_tlast) begin
      case (kind_cur)
        sdf_pkg::KIND_RSSI: begin
          ok_flag  = (total == sdf_pkg::HDR_SHORT);
          rssi_out = rssi_next;
        end
        sdf_pkg::KIND_PAYLOAD, sdf_pkg::KIND_IMMEDIATE: begin
          ok_flag    = (total == sdf_pkg::HDR_SHORT + {2'b00, length_next});
          length_out = length_next;
        end
        sdf_pkg::KIND_SHARING: begin
          ok_flag    = (total == sdf_pkg::HDR_SHARING + {2'b00, length_next});
          rssi_out   = rssi_next;
          length_out = length_next;
        end
        default: begin
        end
      endcase
    end

    // The position restarts after the last byte and otherwise saturates.
    if (s_axis_tlast) begin
      byte_position_next = '0;
    end else if (byte_position != sdf_pkg::POS_MAX) begin
      byte_position_next = total[sdf_pkg::POS_W-1:0];
    end else begin
      byte_position_next = byte_position;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_rssi      <= sdf_pkg::RST_CODE_RSSI;
      code_payload   <= sdf_pkg::RST_CODE_PAYLOAD;
      code_sharing   <= sdf_pkg::RST_CODE_SHARING;
      code_immediate <= sdf_pkg::RST_CODE_IMMEDIATE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdf_pkg::REG_CODE_RSSI:      code_rssi      <= cfg_data;
        sdf_pkg::REG_CODE_PAYLOAD:   code_payload   <= cfg_data;
        sdf_pkg::REG_CODE_SHARING:   code_sharing   <= cfg_data;
        sdf_pkg::REG_CODE_IMMEDIATE: code_immediate <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      kind_reg      <= sdf_pkg::KIND_RSSI;
      rssi_reg      <= '0;
      length_reg    <= '0;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
      kind_reg      <= kind_cur;
      rssi_reg      <= rssi_next;
      length_reg    <= length_next;
    end
  end

  // Result register: valid is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_kind       <= kind_cur;
      res_is_payload <= pay_flag;
      res_payload    <= pay_flag ? s_axis_tdata : '0;
      res_last       <= s_axis_tlast;
      res_ok         <= ok_flag;
      res_rssi       <= rssi_out;
      res_length     <= length_out;
    end
  end

  assign m_axis_tdata = {7'b0, res_length, res_rssi, res_ok, res_payload};
  assign m_axis_tuser = {res_is_payload, res_kind};
  assign m_axis_tlast = res_last;

  // After the last byte of a message the next byte is decoded as an action code.
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast) |=> (byte_position == '0))
    else $error("byte position not cleared after end of message");

  // Payload bytes only come from kinds that carry a payload.
  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_is_payload) |->
      (res_kind == sdf_pkg::KIND_PAYLOAD || res_kind == sdf_pkg::KIND_SHARING ||
       res_kind == sdf_pkg::KIND_IMMEDIATE))
    else $error("payload flagged on a message without payload");

  // Header results are only reported on the last word of a message.
  a_report_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res_last) |->
      (!res_ok && res_rssi == '0 && res_length == '0))
    else $error("message report outside end of message");

  // An accepted message is never of unknown kind.
  a_ok_known: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_ok) |-> (res_kind != sdf_pkg::KIND_UNKNOWN))
    else $error("unknown message reported as valid");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signal message deframer testbench
// Drives framed byte messages under changing action codes and checks each
// result word against an in-bench decoder of the same message format.
// ----------------------------------------------------------------------------
// Stimulus runs in phases. Each phase first sets the four action codes, then
// sends messages. The first phase opens with hand-written messages at reset
// codes: every kind, the field extremes, short and over-long messages. The
// rest is random, mostly well-formed messages with random content, plus
// broken ones. Both stream sides idle in short random bursts, except in the
// final phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  // Indexes from here upwards name no register and must be ignored.
  localparam logic [sdf_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd4;
  localparam logic [sdf_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'd255;

  typedef struct packed {
    sdf_pkg::kind_t kind;
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic        end_of_message;
    logic        message_ok;
    logic [15:0] rssi_value;
    logic [15:0] declared_length;
  } deframe_word_t;

  // Mirror of the deframer: its own code registers and header state, plus the
  // words still owed by the block, oldest first.
  class deframe_tracker;
    logic [7:0]     code [4];
    logic [16:0]    position;
    sdf_pkg::kind_t kind_held;
    logic [15:0]    rssi_acc;
    logic [15:0]    length_acc;
    deframe_word_t  pending_words [$];
    int unsigned    failures;

    function new();
      code[0] = sdf_pkg::RST_CODE_RSSI;
      code[1] = sdf_pkg::RST_CODE_PAYLOAD;
      code[2] = sdf_pkg::RST_CODE_SHARING;
      code[3] = sdf_pkg::RST_CODE_IMMEDIATE;
      position = '0;
      kind_held = sdf_pkg::KIND_RSSI;
      rssi_acc = '0;
      length_acc = '0;
      failures = 0;
    endfunction

    function void write_code(logic [sdf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
      case (idx)
        sdf_pkg::REG_CODE_RSSI:      code[0] = value;
        sdf_pkg::REG_CODE_PAYLOAD:   code[1] = value;
        sdf_pkg::REG_CODE_SHARING:   code[2] = value;
        sdf_pkg::REG_CODE_IMMEDIATE: code[3] = value;
        default: ;
      endcase
    endfunction

    function sdf_pkg::kind_t match_code(logic [7:0] b);
      sdf_pkg::kind_t k;
      k = sdf_pkg::KIND_UNKNOWN;
      if (b == code[3]) k = sdf_pkg::KIND_IMMEDIATE;
      if (b == code[2]) k = sdf_pkg::KIND_SHARING;
      if (b == code[1]) k = sdf_pkg::KIND_PAYLOAD;
      if (b == code[0]) k = sdf_pkg::KIND_RSSI;
      return k;
    endfunction

    // Works out the word owed for one accepted byte and advances the state.
    function void accept_byte(logic [7:0] b, logic last);
      deframe_word_t w;
      int unsigned total;
      w = '0;
      if (position == 0) begin
        kind_held = match_code(b);
        rssi_acc = '0;
        length_acc = '0;
      end
      w.kind = kind_held;
      case (kind_held)
        sdf_pkg::KIND_RSSI: begin
          if (position == 1) rssi_acc[7:0] = b;
          else if (position == 2) rssi_acc[15:8] = b;
        end
        sdf_pkg::KIND_PAYLOAD, sdf_pkg::KIND_IMMEDIATE: begin
          if (position == 1) length_acc[7:0] = b;
          else if (position == 2) length_acc[15:8] = b;
          else if (position >= sdf_pkg::HDR_SHORT) w.is_payload = 1'b1;
        end
        sdf_pkg::KIND_SHARING: begin
          if (position == 1) rssi_acc[7:0] = b;
          else if (position == 2) rssi_acc[15:8] = b;
          else if (position == 3) length_acc[7:0] = b;
          else if (position == 4) length_acc[15:8] = b;
          else if (position >= sdf_pkg::HDR_SHARING) w.is_payload = 1'b1;
        end
        default: ;
      endcase
      if (w.is_payload) w.payload_byte = b;
      w.end_of_message = last;
      if (last) begin
        total = position + 1;
        case (kind_held)
          sdf_pkg::KIND_RSSI: begin
            w.message_ok = (total == sdf_pkg::HDR_SHORT);
            w.rssi_value = rssi_acc;
          end
          sdf_pkg::KIND_PAYLOAD, sdf_pkg::KIND_IMMEDIATE: begin
            w.message_ok = (total == sdf_pkg::HDR_SHORT + length_acc);
            w.declared_length = length_acc;
          end
          sdf_pkg::KIND_SHARING: begin
            w.message_ok = (total == sdf_pkg::HDR_SHARING + length_acc);
            w.rssi_value = rssi_acc;
            w.declared_length = length_acc;
          end
          default: ;
        endcase
        position = '0;
      end else if (position != sdf_pkg::POS_MAX) begin
        position = position + 1'b1;
      end
      pending_words = {pending_words, w};
    endfunction

    function void flag_failure(string text);
      failures++;
      if (failures <= 10) $display("%0t ns: %s", $time, text);
    endfunction

    function void check_word(deframe_word_t got);
      deframe_word_t exp;
      if (pending_words.size() == 0) begin
        flag_failure($sformatf("result word %h arrived with none owed", got));
        return;
      end
      exp = pending_words.pop_front();
      if (got.kind !== exp.kind)
        flag_failure($sformatf("msg_kind: expected %0d, got %0d", exp.kind, got.kind));
      if (got.is_payload !== exp.is_payload)
        flag_failure($sformatf("is_payload: expected %0b, got %0b",
                               exp.is_payload, got.is_payload));
      if (got.payload_byte !== exp.payload_byte)
        flag_failure($sformatf("payload_byte: expected %h, got %h",
                               exp.payload_byte, got.payload_byte));
      if (got.end_of_message !== exp.end_of_message)
        flag_failure($sformatf("end_of_message: expected %0b, got %0b",
                               exp.end_of_message, got.end_of_message));
      if (got.message_ok !== exp.message_ok)
        flag_failure($sformatf("message_ok: expected %0b, got %0b",
                               exp.message_ok, got.message_ok));
      if (got.rssi_value !== exp.rssi_value)
        flag_failure($sformatf("rssi_value: expected %h, got %h",
                               exp.rssi_value, got.rssi_value));
      if (got.declared_length !== exp.declared_length)
        flag_failure($sformatf("declared_length: expected %h, got %h",
                               exp.declared_length, got.declared_length));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  deframe_tracker tracker = new();
  bit             idle_on = 1'b1;
  int unsigned    bytes_sent = 0;
  int unsigned    cycles = 0;
  int unsigned    rx_stall_left = 0;

  signal_message_deframer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Run guard: the run stops with an error once the cycle limit is passed.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[signal_message_deframer_unit] ERROR");
      $finish;
    end
  end

  // Result side. Values are sampled as they stood before the edge, so a word
  // is checked exactly when the handshake completes. tready then idles in
  // short random bursts while idling is switched on.
  always @(posedge clk) begin
    deframe_word_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind            = sdf_pkg::kind_t'(m_axis_tuser[2:0]);
      got.is_payload      = m_axis_tuser[3];
      got.payload_byte    = m_axis_tdata[7:0];
      got.message_ok      = m_axis_tdata[8];
      got.rssi_value      = m_axis_tdata[24:9];
      got.declared_length = m_axis_tdata[40:25];
      got.end_of_message  = m_axis_tlast;
      tracker.check_word(got);
    end
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one byte and returns at the edge that accepts it. tvalid is left
  // high so that the next byte can follow without a gap; it is only lowered
  // for an idle burst or by the caller.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.accept_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg [$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Stops sending and holds off until every owed word has been taken, so the
  // block is idle and the codes may be rewritten.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all four codes, then one write to an index that names no register.
  task automatic program_codes(input logic [7:0] c_rssi, input logic [7:0] c_payload,
                               input logic [7:0] c_sharing, input logic [7:0] c_immediate);
    logic [sdf_pkg::CFG_IDX_W-1:0] idx [5];
    logic [7:0]                    value [5];
    idx[0] = sdf_pkg::REG_CODE_RSSI;      value[0] = c_rssi;
    idx[1] = sdf_pkg::REG_CODE_PAYLOAD;   value[1] = c_payload;
    idx[2] = sdf_pkg::REG_CODE_SHARING;   value[2] = c_sharing;
    idx[3] = sdf_pkg::REG_CODE_IMMEDIATE; value[3] = c_immediate;
    idx[4] = ($urandom_range(0, 3) == 0) ? REG_UNUSED_LAST
                                          : 8'($urandom_range(REG_UNUSED_FIRST, 255));
    value[4] = 8'($urandom);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= value[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.write_code(idx[i], value[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Builds one random message. A well-formed one has the header its kind
  // needs and exactly the payload that its length field declares; a broken
  // one has a wrong length field, is cut short or carries extra bytes.
  function automatic void build_message(ref logic [7:0] msg [$], input bit well_formed);
    int unsigned sel;
    int unsigned plen;
    int unsigned cut;
    logic [15:0] rssi;
    logic [15:0] dlen;
    msg.delete();
    sel  = $urandom_range(0, 4);
    rssi = 16'($urandom);
    plen = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
    dlen = 16'(plen);
    if (!well_formed && $urandom_range(0, 1) == 0) dlen = 16'($urandom);
    msg = {msg, (sel == 4) ? 8'($urandom) : tracker.code[sel]};
    case (sel)
      0: begin
        msg = {msg, rssi[7:0], rssi[15:8]};
        plen = 0;
      end
      1, 3: begin
        msg = {msg, dlen[7:0], dlen[15:8]};
      end
      2: begin
        msg = {msg, rssi[7:0], rssi[15:8], dlen[7:0], dlen[15:8]};
      end
      default: ;
    endcase
    repeat (plen) msg = {msg, 8'($urandom)};
    if (!well_formed) begin
      if (msg.size() > 1 && $urandom_range(0, 1) == 0) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end else begin
        repeat ($urandom_range(1, 3)) msg = {msg, 8'($urandom)};
      end
    end
  endfunction

  task automatic send_random(input int unsigned n_bytes);
    logic [7:0]  msg [$];
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_message(msg, $urandom_range(0, 4) != 0);
      send_message(msg);
      // Now and then the sender holds off until every word has come back.
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  function automatic logic [7:0] random_code();
    return 8'($urandom);
  endfunction

  initial begin
    logic [7:0] c [4];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset codes: rssi 1, payload 2, sharing 3, immediate 4.
    send_message('{8'h01, 8'h00, 8'h80});               // rssi at its most negative
    send_message('{8'h01, 8'hFF, 8'h7F});               // rssi at its most positive
    send_message('{8'h02, 8'h02, 8'h00, 8'h00, 8'hFF}); // payload with extreme bytes
    send_message('{8'h04, 8'h00, 8'h00});               // immediate, empty payload
    send_message('{8'h03, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hA5}); // sharing
    send_message('{8'hFF});                             // unknown code
    send_message('{8'h02});                             // cut off inside the header
    send_message('{8'h03, 8'h12});                      // sharing cut off early
    send_message('{8'h01, 8'h11, 8'h22, 8'h33});        // rssi one byte too long
    send_random(300);
    wait_drained();

    // Extreme codes that coincide in pairs: the earlier kind must win.
    program_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_random(300);
    wait_drained();

    // All four codes equal: only rssi and unknown messages remain.
    c[0] = random_code();
    program_codes(c[0], c[0], c[0], c[0]);
    send_random(200);
    wait_drained();

    // Random codes, with an occasional collision.
    for (int i = 0; i < 4; i++) c[i] = random_code();
    if ($urandom_range(0, 3) == 0) c[3] = c[1];
    program_codes(c[0], c[1], c[2], c[3]);
    send_random(400);
    wait_drained();

    // Final phase without idling on either side.
    idle_on = 1'b0;
    program_codes(8'hFF, 8'hFE, 8'h01, 8'h00);
    send_random(440);
    wait_drained();

    if (tracker.failures == 0 && tracker.pending_words.size() == 0) begin
      $display("[signal_message_deframer_unit] OK");
    end else begin
      $display("[signal_message_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
